// ----- rtl/core/ec_affine_point_add_defines.svh -----
// assertion macros shared by the point adder rtl
// depends on nothing; the including module supplies clk and rst_n
`ifndef EC_AFFINE_POINT_ADD_DEFINES_SVH
`define EC_AFFINE_POINT_ADD_DEFINES_SVH

// same-cycle implication, reset masked
`define EC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define EC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ec_pa_pkg.sv -----
// shared types, status codes and modular add/sub helpers for the point adder
// depends on nothing
package ec_pa_pkg;

  localparam int COORD_BITS = 31;
  localparam int CNT_W      = $clog2(COORD_BITS + 1);
  localparam int DS_W       = COORD_BITS + 1;
  localparam int T_W        = COORD_BITS + 5;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [1:0]            status_t;

  localparam status_t ST_FINITE   = 2'd0;
  localparam status_t ST_INFINITY = 2'd1;
  localparam status_t ST_ERROR    = 2'd2;

  localparam logic ADDR_COEFF_A = 1'b0;
  localparam logic ADDR_PRIME   = 1'b1;

  // (u + v) mod m for u, v below m
  function automatic coord_t mod_add(input coord_t u, input coord_t v, input coord_t m);
    logic [COORD_BITS:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[COORD_BITS-1:0];
  endfunction

  // (u - v) mod m for u, v below m
  function automatic coord_t mod_sub(input coord_t u, input coord_t v, input coord_t m);
    coord_t d;
    if (u >= v) begin
      d = u - v;
    end else begin
      d = u + (m - v);
    end
    return d;
  endfunction

endpackage

// ----- rtl/core/ec_affine_point_add.sv -----
// the five operands are first reduced mod p, then up to four multiplies
// (tangent x^2, lambda, lambda^2, lambda*(x1-x3)) run around the inverse, which takes
// one euclid quotient at a time by aligning the divisor and shift-subtracting it down;
// a special case ends an item early, and a modulus below 3 goes straight to the finish
// throughput: one item in flight; a new item is taken while the last result waits
// reset (rst_n low, synchronous): idle, no result pending, a = 0, p = 2^31-1.
`include "ec_affine_point_add_defines.svh"

module ec_affine_point_add (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // input item
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ec_pa_pkg::COORD_BITS-1:0]   in_first_x,
  input  logic [ec_pa_pkg::COORD_BITS-1:0]   in_first_y,
  input  logic [ec_pa_pkg::COORD_BITS-1:0]   in_second_x,
  input  logic [ec_pa_pkg::COORD_BITS-1:0]   in_second_y,
  // result item
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ec_pa_pkg::COORD_BITS-1:0]   out_sum_x,
  output logic [ec_pa_pkg::COORD_BITS-1:0]   out_sum_y,
  output logic [1:0]                         out_status
);

  typedef enum logic [4:0] {
    S_IDLE, S_RED, S_RED_ST, S_MUL, S_CLASS, S_TAN1, S_TAN2, S_TAN3,
    S_INV_INIT, S_INV, S_ALIGN, S_DIV, S_INV_END, S_LAM, S_SQ, S_X3, S_D,
    S_Y3, S_FIN
  } state_t;

  state_t state_r, mul_ret_r;

  ec_pa_pkg::coord_t coeff_a_r, prime_r;
  ec_pa_pkg::coord_t op_r [0:4];
  logic [2:0]        idx_r;

  // bit-serial multiplier
  ec_pa_pkg::coord_t mu_r, mv_r, mr_r;
  logic [ec_pa_pkg::CNT_W-1:0] cnt_r;

  ec_pa_pkg::coord_t num_r, den_r, tmp_r, lam_r;
  ec_pa_pkg::coord_t res_x_r, res_y_r;
  ec_pa_pkg::status_t res_st_r;

  // extended euclid
  ec_pa_pkg::coord_t r0_r, r1_r;
  logic signed [ec_pa_pkg::T_W-1:0] t0_r, t1_r, dt_r;
  logic [ec_pa_pkg::DS_W-1:0] ds_r;

  logic out_valid_r;
  ec_pa_pkg::coord_t out_x_r, out_y_r;
  ec_pa_pkg::status_t out_st_r;

  logic in_acc, cfg_wr;
  ec_pa_pkg::coord_t x1, y1, x2, y2, a_red, p;
  ec_pa_pkg::coord_t mul_step, inv_val, r0_sub;
  logic [ec_pa_pkg::DS_W:0] ds_dbl;
  logic div_take;
  logic signed [ec_pa_pkg::T_W-1:0] t0_sub, t0_pos;

  assign p      = prime_r;
  assign x1     = op_r[0];
  assign y1     = op_r[1];
  assign x2     = op_r[2];
  assign y2     = op_r[3];
  assign a_red  = op_r[4];
  assign in_acc = in_valid && in_ready;
  assign cfg_wr = psel && penable && pwrite;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sum_x  = out_x_r;
  assign out_sum_y  = out_y_r;
  assign out_status = out_st_r;
  assign pready     = 1'b1;

  // register readback
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      ec_pa_pkg::ADDR_COEFF_A: prdata[ec_pa_pkg::COORD_BITS-1:0] = coeff_a_r;
      ec_pa_pkg::ADDR_PRIME:   prdata[ec_pa_pkg::COORD_BITS-1:0] = prime_r;
      default:                 prdata = '0;
    endcase
  end

  // one multiplier step: r = 2r + bit*v mod p
  assign mul_step = ec_pa_pkg::mod_add(ec_pa_pkg::mod_add(mr_r, mr_r, p),
                                       mu_r[ec_pa_pkg::COORD_BITS-1] ? mv_r : '0, p);

  // division step helpers
  assign ds_dbl   = {ds_r, 1'b0};
  assign div_take = (ds_r <= {1'b0, r0_r});
  assign r0_sub   = div_take ? (r0_r - ds_r[ec_pa_pkg::COORD_BITS-1:0]) : r0_r;
  assign t0_sub   = div_take ? (t0_r - dt_r) : t0_r;

  // final coefficient folded into 0..p-1
  always_comb begin
    t0_pos  = t0_r[ec_pa_pkg::T_W-1] ?
              (t0_r + $signed({{(ec_pa_pkg::T_W-ec_pa_pkg::COORD_BITS){1'b0}}, p})) : t0_r;
    inv_val = t0_pos[ec_pa_pkg::COORD_BITS-1:0];
    if (inv_val >= p) begin
      inv_val = inv_val - p;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_a_r <= '0;
      prime_r   <= '1;
    end else if (cfg_wr) begin
      if (paddr[2] == ec_pa_pkg::ADDR_COEFF_A) begin
        coeff_a_r <= pwdata[ec_pa_pkg::COORD_BITS-1:0];
      end else begin
        prime_r <= pwdata[ec_pa_pkg::COORD_BITS-1:0];
      end
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_ret_r   <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      // the finish state reloads the output register itself
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r[0] <= in_first_x;
            op_r[1] <= in_first_y;
            op_r[2] <= in_second_x;
            op_r[3] <= in_second_y;
            op_r[4] <= coeff_a_r;
            idx_r   <= '0;
            res_x_r <= '0;
            res_y_r <= '0;
            res_st_r <= ec_pa_pkg::ST_ERROR;
            if (prime_r < ec_pa_pkg::COORD_BITS'(3)) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_RED;
            end
          end
        end
        // reduce each operand as operand*1 mod p
        S_RED: begin
          mu_r      <= op_r[idx_r];
          mv_r      <= ec_pa_pkg::COORD_BITS'(1);
          mr_r      <= '0;
          cnt_r     <= '0;
          mul_ret_r <= S_RED_ST;
          state_r   <= S_MUL;
        end
        S_RED_ST: begin
          op_r[idx_r] <= mr_r;
          if (idx_r == 3'd4) begin
            state_r <= S_CLASS;
          end else begin
            idx_r   <= idx_r + 3'd1;
            state_r <= S_RED;
          end
        end
        S_MUL: begin
          mr_r  <= mul_step;
          mu_r  <= {mu_r[ec_pa_pkg::COORD_BITS-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == ec_pa_pkg::CNT_W'(ec_pa_pkg::COORD_BITS - 1)) begin
            state_r <= mul_ret_r;
          end
        end
        // pick chord, tangent or a special case
        S_CLASS: begin
          if (x1 != x2) begin
            num_r   <= ec_pa_pkg::mod_sub(y2, y1, p);
            den_r   <= ec_pa_pkg::mod_sub(x2, x1, p);
            state_r <= S_INV_INIT;
          end else if (y1 == y2) begin
            if (y1 == '0) begin
              res_st_r <= ec_pa_pkg::ST_INFINITY;
              state_r  <= S_FIN;
            end else begin
              mu_r      <= x1;
              mv_r      <= x1;
              mr_r      <= '0;
              cnt_r     <= '0;
              mul_ret_r <= S_TAN1;
              state_r   <= S_MUL;
            end
          end else if (ec_pa_pkg::mod_add(y1, y2, p) == '0) begin
            res_st_r <= ec_pa_pkg::ST_INFINITY;
            state_r  <= S_FIN;
          end else begin
            state_r <= S_FIN;
          end
        end
        // tangent numerator 3x^2 + a, denominator 2y
        S_TAN1: begin
          tmp_r   <= ec_pa_pkg::mod_add(mr_r, mr_r, p);
          state_r <= S_TAN2;
        end
        S_TAN2: begin
          num_r   <= ec_pa_pkg::mod_add(tmp_r, mr_r, p);
          state_r <= S_TAN3;
        end
        S_TAN3: begin
          num_r   <= ec_pa_pkg::mod_add(num_r, a_red, p);
          den_r   <= ec_pa_pkg::mod_add(y1, y1, p);
          state_r <= S_INV_INIT;
        end
        S_INV_INIT: begin
          r0_r    <= p;
          r1_r    <= den_r;
          t0_r    <= '0;
          t1_r    <= ec_pa_pkg::T_W'(1);
          state_r <= S_INV;
        end
        // one euclid quotient: align divisor, then shift-subtract down
        S_INV: begin
          if (r1_r == '0) begin
            state_r <= S_INV_END;
          end else begin
            ds_r    <= {1'b0, r1_r};
            dt_r    <= t1_r;
            cnt_r   <= '0;
            state_r <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          if (ds_dbl <= {2'b00, r0_r}) begin
            ds_r  <= ds_dbl[ec_pa_pkg::DS_W-1:0];
            dt_r  <= dt_r <<< 1;
            cnt_r <= cnt_r + 1'b1;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            r0_r    <= r1_r;
            r1_r    <= r0_sub;
            t0_r    <= t1_r;
            t1_r    <= t0_sub;
            state_r <= S_INV;
          end else begin
            r0_r  <= r0_sub;
            t0_r  <= t0_sub;
            ds_r  <= ds_r >> 1;
            dt_r  <= dt_r >>> 1;
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_INV_END: begin
          if (r0_r != ec_pa_pkg::COORD_BITS'(1)) begin
            state_r <= S_FIN;
          end else begin
            mu_r      <= num_r;
            mv_r      <= inv_val;
            mr_r      <= '0;
            cnt_r     <= '0;
            mul_ret_r <= S_LAM;
            state_r   <= S_MUL;
          end
        end
        S_LAM: begin
          lam_r     <= mr_r;
          mu_r      <= mr_r;
          mv_r      <= mr_r;
          mr_r      <= '0;
          cnt_r     <= '0;
          mul_ret_r <= S_SQ;
          state_r   <= S_MUL;
        end
        // x3 = l^2 - x1 - x2
        S_SQ: begin
          tmp_r   <= ec_pa_pkg::mod_sub(mr_r, x1, p);
          state_r <= S_X3;
        end
        S_X3: begin
          res_x_r <= ec_pa_pkg::mod_sub(tmp_r, x2, p);
          state_r <= S_D;
        end
        S_D: begin
          mu_r      <= lam_r;
          mv_r      <= ec_pa_pkg::mod_sub(x1, res_x_r, p);
          mr_r      <= '0;
          cnt_r     <= '0;
          mul_ret_r <= S_Y3;
          state_r   <= S_MUL;
        end
        // y3 = l*(x1 - x3) - y1
        S_Y3: begin
          res_y_r  <= ec_pa_pkg::mod_sub(mr_r, y1, p);
          res_st_r <= ec_pa_pkg::ST_FINITE;
          state_r  <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_x_r     <= res_x_r;
            out_y_r     <= res_y_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  `EC_ASSERT_NOW(a_zero_unless_finite,
    out_valid && (out_status != ec_pa_pkg::ST_FINITE),
    (out_sum_x == '0) && (out_sum_y == '0), "nonzero coordinates on non-finite item")
  `EC_ASSERT_NOW(a_status_legal, out_valid,
    (out_status == ec_pa_pkg::ST_FINITE) || (out_status == ec_pa_pkg::ST_INFINITY) ||
    (out_status == ec_pa_pkg::ST_ERROR), "illegal status code")
  `EC_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready, "item accepted but block idle")
  `EC_ASSERT_NOW(a_mul_count, state_r == S_MUL,
    cnt_r < ec_pa_pkg::CNT_W'(ec_pa_pkg::COORD_BITS), "multiplier ran past its width")

endmodule
